### rtl/deflate_lz77_symbol_expander_top_defines.svh
// ----------------------------------------------------------------------------
// DEFLATE LZ77 symbol expander assertion macros
// Shared concurrent check forms, clocked and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef DEFLATE_LZ77_SYMBOL_EXPANDER_TOP_DEFINES_SVH
`define DEFLATE_LZ77_SYMBOL_EXPANDER_TOP_DEFINES_SVH

// same-cycle implication
`define DLSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlse: same-cycle check failed");

// next-cycle implication
`define DLSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlse: next-cycle check failed");

`endif

### rtl/dlse_pkg.sv
// ----------------------------------------------------------------------------
// DEFLATE LZ77 symbol expander package
// Field widths, symbol codes, command and result types, DEFLATE tables.
// ----------------------------------------------------------------------------
package dlse_pkg;

    localparam int SYM_W   = 9;
    localparam int LX_W    = 5;
    localparam int DC_W    = 5;
    localparam int DX_W    = 13;
    localparam int LANES_W = 64;
    localparam int COUNT_W = 4;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 9;
    localparam int DIST_W  = 16;
    localparam int LI_W    = 5;

    localparam logic [SYM_W-1:0] SYM_END       = 9'd256;
    localparam logic [SYM_W-1:0] SYM_FIRST_LEN = 9'd257;
    localparam logic [SYM_W-1:0] SYM_LIMIT     = 9'd286;
    localparam logic [DC_W-1:0]  DIST_CODES    = 5'd30;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_BAD_SYMBOL,
        ERR_BAD_DIST_CODE,
        ERR_DIST_TOO_FAR
    } err_t;

    typedef enum logic [2:0] {
        CMD_LITERAL,
        CMD_END,
        CMD_BAD_SYMBOL,
        CMD_BAD_DIST,
        CMD_MATCH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  lit;
        logic [LEN_W-1:0]   len;
        logic [DIST_W-1:0]  distance;
    } cmd_t;

    typedef struct packed {
        logic [LANES_W-1:0] lanes;
        logic [COUNT_W-1:0] count;
        logic               eob;
        err_t               err;
        logic               last;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } back_state_t;

    function automatic logic [LEN_W-1:0] len_start(input logic [LI_W-1:0] li);
        logic [LEN_W-1:0] v;
        unique case (li)
            5'd0:    v = 9'd3;
            5'd1:    v = 9'd4;
            5'd2:    v = 9'd5;
            5'd3:    v = 9'd6;
            5'd4:    v = 9'd7;
            5'd5:    v = 9'd8;
            5'd6:    v = 9'd9;
            5'd7:    v = 9'd10;
            5'd8:    v = 9'd11;
            5'd9:    v = 9'd13;
            5'd10:   v = 9'd15;
            5'd11:   v = 9'd17;
            5'd12:   v = 9'd19;
            5'd13:   v = 9'd23;
            5'd14:   v = 9'd27;
            5'd15:   v = 9'd31;
            5'd16:   v = 9'd35;
            5'd17:   v = 9'd43;
            5'd18:   v = 9'd51;
            5'd19:   v = 9'd59;
            5'd20:   v = 9'd67;
            5'd21:   v = 9'd83;
            5'd22:   v = 9'd99;
            5'd23:   v = 9'd115;
            5'd24:   v = 9'd131;
            5'd25:   v = 9'd163;
            5'd26:   v = 9'd195;
            5'd27:   v = 9'd227;
            5'd28:   v = 9'd258;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] len_xbits(input logic [LI_W-1:0] li);
        logic [2:0] v;
        if (li >= 5'd28 || li < 5'd8)
        begin
            v = 3'd0;
        end
        else
        begin
            v = 3'(li[4:2] - 3'd1);
        end
        return v;
    endfunction

    function automatic logic [DIST_W-1:0] dist_start(input logic [DC_W-1:0] dc);
        logic [DIST_W-1:0] v;
        unique case (dc)
            5'd0:    v = 16'd1;
            5'd1:    v = 16'd2;
            5'd2:    v = 16'd3;
            5'd3:    v = 16'd4;
            5'd4:    v = 16'd5;
            5'd5:    v = 16'd7;
            5'd6:    v = 16'd9;
            5'd7:    v = 16'd13;
            5'd8:    v = 16'd17;
            5'd9:    v = 16'd25;
            5'd10:   v = 16'd33;
            5'd11:   v = 16'd49;
            5'd12:   v = 16'd65;
            5'd13:   v = 16'd97;
            5'd14:   v = 16'd129;
            5'd15:   v = 16'd193;
            5'd16:   v = 16'd257;
            5'd17:   v = 16'd385;
            5'd18:   v = 16'd513;
            5'd19:   v = 16'd769;
            5'd20:   v = 16'd1025;
            5'd21:   v = 16'd1537;
            5'd22:   v = 16'd2049;
            5'd23:   v = 16'd3073;
            5'd24:   v = 16'd4097;
            5'd25:   v = 16'd6145;
            5'd26:   v = 16'd8193;
            5'd27:   v = 16'd12289;
            5'd28:   v = 16'd16385;
            5'd29:   v = 16'd24577;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] dist_xbits(input logic [DC_W-1:0] dc);
        logic [3:0] v;
        if (dc < 5'd4 || dc >= DIST_CODES)
        begin
            v = 4'd0;
        end
        else
        begin
            v = 4'(dc[4:1] - 4'd1);
        end
        return v;
    endfunction

endpackage

### rtl/dlse_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dlse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/dlse_fifo.sv
// ----------------------------------------------------------------------------
// Small flip-flop FIFO
// Queue between the decode front and the copy engine, and the result queue.
// ----------------------------------------------------------------------------
module dlse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/dlse_front.sv
// ----------------------------------------------------------------------------
// Symbol decode front
// Classifies each item and resolves length and distance from the tables.
// ----------------------------------------------------------------------------
module dlse_front (
    input  logic                       push,
    output logic                       full,
    input  logic [dlse_pkg::SYM_W-1:0] symbol,
    input  logic [dlse_pkg::LX_W-1:0]  length_extra,
    input  logic [dlse_pkg::DC_W-1:0]  distance_code,
    input  logic [dlse_pkg::DX_W-1:0]  distance_extra,
    input  logic                       q_full,
    output logic                       q_wr,
    output dlse_pkg::cmd_t             cmd
);

    logic [dlse_pkg::LI_W-1:0] li;
    logic [2:0]                lx_bits;
    logic [3:0]                dx_bits;
    logic [dlse_pkg::LX_W-1:0] lx_mask;
    logic [dlse_pkg::DX_W-1:0] dx_mask;

    assign full = q_full;
    assign q_wr = push && !q_full;

    assign li      = dlse_pkg::LI_W'(symbol - dlse_pkg::SYM_FIRST_LEN);
    assign lx_bits = dlse_pkg::len_xbits(li);
    assign dx_bits = dlse_pkg::dist_xbits(distance_code);

    always_comb
    begin
        for (int j = 0; j < dlse_pkg::LX_W; j++)
        begin
            lx_mask[j] = (j < int'(lx_bits));
        end
        for (int j = 0; j < dlse_pkg::DX_W; j++)
        begin
            dx_mask[j] = (j < int'(dx_bits));
        end
    end

    always_comb
    begin
        cmd.lit      = symbol[dlse_pkg::BYTE_W-1:0];
        cmd.len      = dlse_pkg::len_start(li)
                     + dlse_pkg::LEN_W'(length_extra & lx_mask);
        cmd.distance = dlse_pkg::dist_start(distance_code)
                     + dlse_pkg::DIST_W'(distance_extra & dx_mask);
        priority if (symbol < dlse_pkg::SYM_END)
        begin
            cmd.kind = dlse_pkg::CMD_LITERAL;
        end
        else if (symbol == dlse_pkg::SYM_END)
        begin
            cmd.kind = dlse_pkg::CMD_END;
        end
        else if (symbol >= dlse_pkg::SYM_LIMIT)
        begin
            cmd.kind = dlse_pkg::CMD_BAD_SYMBOL;
        end
        else if (distance_code >= dlse_pkg::DIST_CODES)
        begin
            cmd.kind = dlse_pkg::CMD_BAD_DIST;
        end
        else
        begin
            cmd.kind = dlse_pkg::CMD_MATCH;
        end
    end

endmodule

### rtl/dlse_back.sv
// ----------------------------------------------------------------------------
// Copy engine back end
// Owns the history window, runs literals and matches, packs result items.
// ----------------------------------------------------------------------------
`include "deflate_lz77_symbol_expander_top_defines.svh"

module dlse_back #(
    parameter int WINDOW_BYTES     = 32768,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  dlse_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    input  logic              out_full,
    output logic              out_wr,
    output dlse_pkg::result_t out_data
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int HW = $clog2(WINDOW_BYTES + 1);
    localparam int EW = dlse_pkg::DIST_W + 1;
    localparam logic [EW-1:0] WIN_E = EW'(WINDOW_BYTES);

    dlse_pkg::back_state_t state_reg, state_next;

    logic [AW-1:0]                    wp_reg, wp_next;
    logic [HW-1:0]                    held_reg, held_next;
    logic [dlse_pkg::BYTE_W-1:0]      last_byte_reg, last_byte_next;
    logic [AW-1:0]                    src_reg, src_next;
    logic [dlse_pkg::LEN_W-1:0]       issue_left_reg, issue_left_next;
    logic [dlse_pkg::LEN_W-1:0]       take_left_reg, take_left_next;
    logic                             byte_vld_reg, byte_vld_next;
    logic                             dist_one_reg, dist_one_next;
    logic [dlse_pkg::COUNT_W-1:0]     fill_reg, fill_next;
    logic [dlse_pkg::LANES_W-1:0]     lanes_reg, lanes_next;

    logic                             ram_rd_en;
    logic [dlse_pkg::BYTE_W-1:0]      ram_rd_data;
    logic                             do_push;
    logic [dlse_pkg::BYTE_W-1:0]      push_data;

    logic [EW-1:0]                    dist_e, src_sum;
    logic                             too_far;
    logic [AW-1:0]                    src_start;
    logic [dlse_pkg::BYTE_W-1:0]      cur_byte;
    logic                             complete;
    logic                             consume;
    logic [dlse_pkg::LANES_W-1:0]     lanes_acc;

    assign dist_e    = EW'(cmd.distance);
    assign too_far   = dist_e > EW'(held_reg);
    assign src_sum   = EW'(wp_reg) + (WIN_E - dist_e);
    assign src_start = (src_sum >= WIN_E) ? AW'(src_sum - WIN_E) : AW'(src_sum);

    assign cur_byte = dist_one_reg ? last_byte_reg : ram_rd_data;
    assign complete = (fill_reg == dlse_pkg::COUNT_W'(BYTES_PER_RESULT - 1))
                   || (take_left_reg == dlse_pkg::LEN_W'(1));

    always_comb
    begin
        lanes_acc = lanes_reg;
        for (int j = 0; j < BYTES_PER_RESULT; j++)
        begin
            if (fill_reg == dlse_pkg::COUNT_W'(j))
            begin
                lanes_acc[j*dlse_pkg::BYTE_W +: dlse_pkg::BYTE_W] = cur_byte;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        src_next        = src_reg;
        issue_left_next = issue_left_reg;
        take_left_next  = take_left_reg;
        byte_vld_next   = byte_vld_reg;
        dist_one_next   = dist_one_reg;
        fill_next       = fill_reg;
        lanes_next      = lanes_reg;
        cmd_pop         = 1'b0;
        out_wr          = 1'b0;
        out_data        = '0;
        do_push         = 1'b0;
        push_data       = cmd.lit;
        ram_rd_en       = 1'b0;
        consume         = 1'b0;

        unique case (state_reg)
            dlse_pkg::ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd.kind)
                        dlse_pkg::CMD_LITERAL:
                        begin
                            if (!out_full)
                            begin
                                out_wr         = 1'b1;
                                out_data.lanes = dlse_pkg::LANES_W'(cmd.lit);
                                out_data.count = dlse_pkg::COUNT_W'(1);
                                out_data.last  = 1'b1;
                                do_push        = 1'b1;
                                cmd_pop        = 1'b1;
                            end
                        end
                        dlse_pkg::CMD_END:
                        begin
                            if (!out_full)
                            begin
                                out_wr        = 1'b1;
                                out_data.eob  = 1'b1;
                                out_data.last = 1'b1;
                                cmd_pop       = 1'b1;
                            end
                        end
                        dlse_pkg::CMD_BAD_SYMBOL:
                        begin
                            if (!out_full)
                            begin
                                out_wr        = 1'b1;
                                out_data.err  = dlse_pkg::ERR_BAD_SYMBOL;
                                out_data.last = 1'b1;
                                cmd_pop       = 1'b1;
                            end
                        end
                        dlse_pkg::CMD_BAD_DIST:
                        begin
                            if (!out_full)
                            begin
                                out_wr        = 1'b1;
                                out_data.err  = dlse_pkg::ERR_BAD_DIST_CODE;
                                out_data.last = 1'b1;
                                cmd_pop       = 1'b1;
                            end
                        end
                        dlse_pkg::CMD_MATCH:
                        begin
                            if (too_far)
                            begin
                                if (!out_full)
                                begin
                                    out_wr        = 1'b1;
                                    out_data.err  = dlse_pkg::ERR_DIST_TOO_FAR;
                                    out_data.last = 1'b1;
                                    cmd_pop       = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd_pop         = 1'b1;
                                src_next        = src_start;
                                issue_left_next = cmd.len;
                                take_left_next  = cmd.len;
                                dist_one_next   = (cmd.distance == dlse_pkg::DIST_W'(1));
                                fill_next       = '0;
                                lanes_next      = '0;
                                state_next      = dlse_pkg::ST_COPY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            dlse_pkg::ST_COPY:
            begin
                consume   = byte_vld_reg && (!complete || !out_full);
                ram_rd_en = (issue_left_reg != '0) && (!byte_vld_reg || consume);
                if (ram_rd_en)
                begin
                    src_next = (src_reg == AW'(WINDOW_BYTES - 1)) ? '0 : src_reg + 1'b1;
                    issue_left_next = issue_left_reg - 1'b1;
                    byte_vld_next   = 1'b1;
                end
                else if (consume)
                begin
                    byte_vld_next = 1'b0;
                end
                if (consume)
                begin
                    do_push        = 1'b1;
                    push_data      = cur_byte;
                    take_left_next = take_left_reg - 1'b1;
                    if (complete)
                    begin
                        out_wr         = 1'b1;
                        out_data.lanes = lanes_acc;
                        out_data.count = fill_reg + 1'b1;
                        out_data.last  = (take_left_reg == dlse_pkg::LEN_W'(1));
                        fill_next      = '0;
                        lanes_next     = '0;
                        if (take_left_reg == dlse_pkg::LEN_W'(1))
                        begin
                            state_next = dlse_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        fill_next  = fill_reg + 1'b1;
                        lanes_next = lanes_acc;
                    end
                end
            end
            default:
            begin
                state_next = dlse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wp_next        = wp_reg;
        held_next      = held_reg;
        last_byte_next = last_byte_reg;
        if (do_push)
        begin
            wp_next        = (wp_reg == AW'(WINDOW_BYTES - 1)) ? '0 : wp_reg + 1'b1;
            last_byte_next = push_data;
            if (held_reg != HW'(WINDOW_BYTES))
            begin
                held_next = held_reg + 1'b1;
            end
        end
    end

    dlse_ram #(
        .WIDTH (dlse_pkg::BYTE_W),
        .DEPTH (WINDOW_BYTES)
    ) u_window (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (wp_reg),
        .wr_data (push_data),
        .rd_en   (ram_rd_en),
        .rd_addr (src_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dlse_pkg::ST_IDLE;
            wp_reg         <= '0;
            held_reg       <= '0;
            issue_left_reg <= '0;
            take_left_reg  <= '0;
            byte_vld_reg   <= 1'b0;
            fill_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            held_reg       <= held_next;
            issue_left_reg <= issue_left_next;
            take_left_reg  <= take_left_next;
            byte_vld_reg   <= byte_vld_next;
            fill_reg       <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_byte_reg <= last_byte_next;
        src_reg       <= src_next;
        dist_one_reg  <= dist_one_next;
        lanes_reg     <= lanes_next;
    end

    `DLSE_ASSERT_IMPL(a_push_has_room, clk, rst_n, out_wr, !out_full)
    `DLSE_ASSERT_IMPL(a_idle_no_flight, clk, rst_n, state_reg == dlse_pkg::ST_IDLE, !byte_vld_reg)
    `DLSE_ASSERT_IMPL(a_copy_balance, clk, rst_n, state_reg == dlse_pkg::ST_COPY,
        take_left_reg == issue_left_reg + dlse_pkg::LEN_W'(byte_vld_reg))
    `DLSE_ASSERT_IMPL(a_wp_tracks_held, clk, rst_n, held_reg != HW'(WINDOW_BYTES),
        AW'(held_reg) == wp_reg)
    `DLSE_ASSERT_IMPL(a_pop_in_copy, clk, rst_n, state_reg == dlse_pkg::ST_COPY, !cmd_pop)

endmodule

### rtl/deflate_lz77_symbol_expander_top.sv
// ----------------------------------------------------------------------------
// DEFLATE LZ77 symbol expander
// Expands decoded literal/length symbols against a history window.
//
//   channel   handshake        payload
//   -------   --------------   ----------------------------------------------
//   input     push / full      symbol, length_extra, distance_code,
//                              distance_extra
//   result    pop / empty      byte_lanes, byte_count, end_of_block,
//                              error_code, last_of_run
//
// Literal, end and error items leave the copy engine from its idle state.
// A match is taken in the idle state, then one window read ahead, then
// one window read and one window write per byte, up to BYTES_PER_RESULT per item.
// Reset clears pointers and queues at once; the window needs no clearing pass.
// A full result queue stalls the copy engine; a busy engine fills the
// two-entry command queue, which then raises full.
// ----------------------------------------------------------------------------
module deflate_lz77_symbol_expander_top #(
    parameter int WINDOW_BYTES     = 32768,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [dlse_pkg::SYM_W-1:0]   symbol,
    input  logic [dlse_pkg::LX_W-1:0]    length_extra,
    input  logic [dlse_pkg::DC_W-1:0]    distance_code,
    input  logic [dlse_pkg::DX_W-1:0]    distance_extra,
    output logic                         empty,
    input  logic                         pop,
    output logic [dlse_pkg::LANES_W-1:0] byte_lanes,
    output logic [dlse_pkg::COUNT_W-1:0] byte_count,
    output logic                         end_of_block,
    output logic [1:0]                   error_code,
    output logic                         last_of_run
);

    localparam int CMD_W = $bits(dlse_pkg::cmd_t);
    localparam int RES_W = $bits(dlse_pkg::result_t);

    dlse_pkg::cmd_t    front_cmd, back_cmd;
    dlse_pkg::result_t back_res, out_res;
    logic              q_wr, q_full, q_empty, q_pop;
    logic              out_wr, out_full;

    dlse_front u_front (
        .push           (push),
        .full           (full),
        .symbol         (symbol),
        .length_extra   (length_extra),
        .distance_code  (distance_code),
        .distance_extra (distance_extra),
        .q_full         (q_full),
        .q_wr           (q_wr),
        .cmd            (front_cmd)
    );

    dlse_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (front_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (back_cmd),
        .empty   (q_empty)
    );

    dlse_back #(
        .WINDOW_BYTES     (WINDOW_BYTES),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (q_empty),
        .cmd       (back_cmd),
        .cmd_pop   (q_pop),
        .out_full  (out_full),
        .out_wr    (out_wr),
        .out_data  (back_res)
    );

    dlse_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data (back_res),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign byte_lanes   = out_res.lanes;
    assign byte_count   = out_res.count;
    assign end_of_block = out_res.eob;
    assign error_code   = out_res.err;
    assign last_of_run  = out_res.last;

endmodule
